// ===== rtl/response_curve_gap_filler_core_macros.svh =====
// Assertion macros used by the datapath (rgf_dp).
`ifndef RESPONSE_CURVE_GAP_FILLER_CORE_MACROS_SVH
`define RESPONSE_CURVE_GAP_FILLER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge out of reset.
`define RGF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("rgf check failed");
// Antecedent implies consequent in the same cycle.
`define RGF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rgf check failed");
`else
`define RGF_ASSERT(lbl, clk, rstn, prop)
`define RGF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/rgf_pkg.sv =====
package rgf_pkg;

    localparam int MAX_LEVELS_DEF = 4096;
    localparam int VAL_W = 32;
    localparam int WT_W  = 16;
    localparam int CNT_W = 13;
    localparam int IDX_W = 12;

    localparam logic [WT_W-1:0]  FILL_WEIGHT_RST = 16'd16;
    localparam logic [CNT_W-1:0] COUNT_MAX       = 13'd8191;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_READ    = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic signed [VAL_W-1:0] response_value;
        logic [WT_W-1:0]         level_weight;
        logic                    last;
        logic [IDX_W-1:0]        read_index;
    } in_item_t;

    typedef struct packed {
        logic                    result_kind;
        logic signed [VAL_W-1:0] out_value;
        logic [WT_W-1:0]         out_weight;
        logic                    was_filled;
        logic [CNT_W-1:0]        gap_count;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic last;
        logic rd_req;
        logic rd_out;
        logic scan;
        logic eval;
        logic step;
        logic div_wait;
        logic fill;
        logic done;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;
        logic gap;
        logic stop;
        logic use_div;
        logic div_done;
        logic fill_end;
        logic fill_last;
    } stat_t;

endpackage

// ===== rtl/rgf_ram.sv =====
module rgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rgf_div.sv =====
// Restoring divider, signed 33-bit dividend by unsigned divisor, one bit per cycle.
module rgf_div #(
    parameter int DW = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] dividend,
    input  logic [DW-1:0]      divisor,
    output logic               done,
    output logic signed [32:0] quotient
);

    localparam int QW = 33;

    logic [QW-1:0]  q_reg, q_next;
    logic [DW:0]    rem_reg, rem_next;
    logic [DW-1:0]  den_reg;
    logic           neg_reg;
    logic [5:0]     cnt_reg, cnt_next;
    logic           run_reg, run_next;
    logic           done_reg, done_next;
    logic [DW:0]    rem_sh;
    logic [DW:0]    diff;

    // one quotient bit per cycle
    always_comb
    begin
        rem_sh    = {rem_reg[DW-1:0], q_reg[QW-1]};
        diff      = rem_sh - {1'b0, den_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend[32] ? QW'(-dividend) : QW'(dividend);
            rem_next = '0;
            cnt_next = 6'(QW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[DW])
            begin
                rem_next = diff;
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= divisor;
            neg_reg <= dividend[32];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

// ===== rtl/rgf_dp.sv =====
`include "response_curve_gap_filler_core_macros.svh"

module rgf_dp #(
    parameter int MAX_LEVELS = rgf_pkg::MAX_LEVELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rgf_pkg::cmd_t     cmd,
    output rgf_pkg::stat_t    stat,
    input  rgf_pkg::in_item_t item,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    output logic              result_valid,
    output rgf_pkg::result_t  result
);

    localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CW = $clog2(MAX_LEVELS + 1);
    localparam int MW = rgf_pkg::VAL_W + rgf_pkg::WT_W + 1;
    localparam int VW = rgf_pkg::VAL_W;
    localparam int NW = rgf_pkg::CNT_W;

    // configuration and table bookkeeping
    logic [rgf_pkg::WT_W-1:0] fill_weight_reg;
    logic [CW-1:0]            level_count_reg, level_count_next;
    logic                     closed_reg;
    logic [NW-1:0]            filled_total_reg;

    // fill scan state
    logic [CW-1:0]            i_reg, lo_reg, hi_reg, m_reg;
    logic signed [VW-1:0]     v_lo_reg, v_lom1_reg, vh_reg, cur_reg;
    logic signed [VW:0]       step_reg;
    logic                     gap_reg;
    logic [NW-1:0]            count_reg;

    // read return
    logic                     rd_oob_reg;
    logic                     result_valid_reg;
    rgf_pkg::result_t         result_reg;

    // memory
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [MW-1:0]            mem_wdata, mem_rdata;
    logic signed [VW-1:0]     rd_value;

    logic [CW-1:0]            lc_eff;
    logic                     full;
    logic signed [VW:0]       half_diff, half_step, div_num;
    logic signed [VW+1:0]     sum;
    logic signed [VW-1:0]     fill_val;
    logic                     div_done;
    logic signed [VW:0]       div_quot;

    // load address: a closed table restarts at level 0
    assign lc_eff           = closed_reg ? '0 : level_count_reg;
    assign full             = (lc_eff == CW'(MAX_LEVELS));
    assign level_count_next = full ? lc_eff : lc_eff + CW'(1);

    assign rd_value  = $signed(mem_rdata[MW-1 -: VW]);

    // half the gradient before the gap, truncated toward zero
    assign half_diff = (VW+1)'(v_lo_reg) - (VW+1)'(v_lom1_reg);
    assign half_step = (half_diff + $signed((VW+1)'({1'b0, half_diff[VW]}))) >>> 1;
    assign div_num   = (VW+1)'(vh_reg) - (VW+1)'(v_lo_reg);

    // saturating fill value
    assign sum = (VW+2)'(cur_reg) + (VW+2)'(step_reg);
    always_comb
    begin
        if (sum > (VW+2)'(32'sh7fffffff))
        begin
            fill_val = 32'sh7fffffff;
        end
        else if (sum < -(VW+2)'(33'sh080000000))
        begin
            fill_val = 32'sh80000000;
        end
        else
        begin
            fill_val = VW'(sum);
        end
    end

    // memory port mux
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = lc_eff[AW-1:0];
        mem_wdata = {item.response_value, item.level_weight, 1'b0};
        if (cmd.load && !full)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.fill && !stat.fill_end)
        begin
            mem_we    = 1'b1;
            mem_waddr = m_reg[AW-1:0];
            mem_wdata = {fill_val, fill_weight_reg, 1'b1};
        end
        mem_raddr = cmd.rd_req ? AW'(item.read_index) : i_reg[AW-1:0];
    end

    rgf_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_LEVELS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rgf_div #(
        .DW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.step && stat.use_div),
        .dividend (div_num),
        .divisor  (hi_reg - lo_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // status
    assign stat.scan_end  = (i_reg >= level_count_reg);
    assign stat.gap       = gap_reg;
    assign stat.stop      = gap_reg && (rd_value != '0);
    assign stat.use_div   = (vh_reg > 0);
    assign stat.div_done  = div_done;
    assign stat.fill_end  = (m_reg == hi_reg);
    assign stat.fill_last = (hi_reg == level_count_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_weight_reg  <= rgf_pkg::FILL_WEIGHT_RST;
            level_count_reg  <= '0;
            closed_reg       <= 1'b0;
            filled_total_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.rd_out || cmd.done;
            if (cfg_we)
            begin
                fill_weight_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                level_count_reg <= level_count_next;
                closed_reg      <= 1'b0;
            end
            if (cmd.done)
            begin
                filled_total_reg <= count_reg;
                closed_reg       <= 1'b1;
            end
        end
    end

    // fill scan and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load && cmd.last)
        begin
            i_reg      <= '0;
            lo_reg     <= '0;
            v_lo_reg   <= '0;
            v_lom1_reg <= '0;
            gap_reg    <= 1'b0;
            count_reg  <= '0;
        end
        if (cmd.rd_req)
        begin
            rd_oob_reg <= (32'(item.read_index) >= 32'(MAX_LEVELS));
        end
        if (cmd.scan && stat.scan_end)
        begin
            hi_reg <= level_count_reg;
            vh_reg <= '0;
        end
        if (cmd.eval)
        begin
            if (i_reg == '0)
            begin
                v_lo_reg <= rd_value;
                i_reg    <= i_reg + CW'(1);
            end
            else if (rd_value == '0)
            begin
                gap_reg <= 1'b1;
                i_reg   <= i_reg + CW'(1);
            end
            else if (!gap_reg)
            begin
                v_lom1_reg <= v_lo_reg;
                v_lo_reg   <= rd_value;
                lo_reg     <= i_reg;
                i_reg      <= i_reg + CW'(1);
            end
            else
            begin
                hi_reg <= i_reg;
                vh_reg <= rd_value;
            end
        end
        if (cmd.step)
        begin
            m_reg   <= lo_reg + CW'(1);
            cur_reg <= v_lo_reg;
            if (!stat.use_div)
            begin
                step_reg <= half_step;
            end
        end
        if (cmd.div_wait && div_done)
        begin
            step_reg <= div_quot;
        end
        if (cmd.fill)
        begin
            if (!stat.fill_end)
            begin
                cur_reg <= fill_val;
                m_reg   <= m_reg + CW'(1);
                if (count_reg != rgf_pkg::COUNT_MAX)
                begin
                    count_reg <= count_reg + NW'(1);
                end
            end
            else
            begin
                v_lom1_reg <= cur_reg;
                v_lo_reg   <= vh_reg;
                lo_reg     <= hi_reg;
                gap_reg    <= 1'b0;
                i_reg      <= hi_reg + CW'(1);
            end
        end
        if (cmd.rd_out)
        begin
            result_reg.result_kind <= rgf_pkg::KIND_READ;
            result_reg.out_value   <= rd_oob_reg ? '0 : rd_value;
            result_reg.out_weight  <= rd_oob_reg ? '0 : mem_rdata[rgf_pkg::WT_W:1];
            result_reg.was_filled  <= rd_oob_reg ? 1'b0 : mem_rdata[0];
            result_reg.gap_count   <= filled_total_reg;
        end
        if (cmd.done)
        begin
            result_reg.result_kind <= rgf_pkg::KIND_SUMMARY;
            result_reg.out_value   <= '0;
            result_reg.out_weight  <= '0;
            result_reg.was_filled  <= 1'b0;
            result_reg.gap_count   <= count_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    `RGF_ASSERT(a_strobe_single, clk, rst_n, result_valid_reg |=> !result_valid_reg)
    `RGF_ASSERT_IMP(a_fill_in_gap, clk, rst_n, cmd.fill && !stat.fill_end, m_reg < hi_reg)
    `RGF_ASSERT_IMP(a_stop_not_first, clk, rst_n, cmd.eval && stat.stop, i_reg != '0)

endmodule

// ===== rtl/rgf_ctrl.sv =====
module rgf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              mode,
    input  logic              last,
    input  rgf_pkg::stat_t    stat,
    output rgf_pkg::cmd_t     cmd,
    output logic              busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OUT,
        S_SCAN,
        S_EVAL,
        S_STEP,
        S_DIV,
        S_FILL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode == rgf_pkg::MODE_READ)
                    begin
                        cmd.rd_req = 1'b1;
                        state_next = S_RD_OUT;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        cmd.last = last;
                        if (last)
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_RD_OUT:
            begin
                cmd.rd_out = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (!stat.scan_end)
                begin
                    state_next = S_EVAL;
                end
                else if (stat.gap)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.stop ? S_STEP : S_SCAN;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.use_div ? S_DIV : S_FILL;
            end
            S_DIV:
            begin
                cmd.div_wait = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.fill_end)
                begin
                    state_next = stat.fill_last ? S_DONE : S_SCAN;
                end
            end
            S_DONE:
            begin
                cmd.done   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/response_curve_gap_filler_core.sv =====
// Load beat: no result. Read beat: the RAM read and state S_RD_OUT lie between accept and
// the registered result strobe; the next accept waits for S_IDLE. Last load beat: fill walk
// reads each level in S_SCAN and S_EVAL, passes S_STEP once per gap, writes each gap entry
// in S_FILL and closes the gap there, and waits on the divider in S_DIV once per gap that
// ends on a positive level; summary strobe follows. Results show for one cycle; no stall.
// Reset (rst_n, async low) clears the level count, fill total and sets fill weight to 16.
module response_curve_gap_filler_core #(
    parameter int MAX_LEVELS = rgf_pkg::MAX_LEVELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rgf_pkg::in_item_t item,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    output logic              result_valid,
    output rgf_pkg::result_t  result
);

    rgf_pkg::cmd_t  cmd;
    rgf_pkg::stat_t stat;

    rgf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (item.mode),
        .last  (item.last),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rgf_dp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int LEVELS     = rgf_pkg::MAX_LEVELS_DEF;
    localparam int STALL_MAX  = 400000;
    localparam int SETTLE     = 60;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    rgf_pkg::in_item_t item;
    logic              cfg_we;
    logic [15:0]       cfg_wdata;
    logic              result_valid;
    rgf_pkg::result_t  result;

    // Curve table model: tracks stores, fill pass and expected beats
    class curve_scoreboard;
        logic signed [31:0] value_tbl [LEVELS];
        logic [15:0]        weight_tbl [LEVELS];
        bit                 mark_tbl [LEVELS];
        bit                 loaded [LEVELS];
        int                 loaded_idx [$];
        int                 level_cnt;
        logic [12:0]        fill_cnt;
        bit                 closed;
        logic [15:0]        fill_weight;
        rgf_pkg::result_t   pending [$];
        int                 errors;

        function new();
            level_cnt   = 0;
            fill_cnt    = 0;
            closed      = 0;
            fill_weight = rgf_pkg::FILL_WEIGHT_RST;
            errors      = 0;
        endfunction

        function longint level_at(longint i);
            if (i < 0 || i >= level_cnt)
                return 0;
            return longint'(value_tbl[i]);
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        // Walk the table, fill each zero run with linear steps
        function logic [12:0] fill_table();
            longint n;
            longint lo;
            longint hi;
            longint stp;
            int     cnt;
            n   = level_cnt;
            hi  = 0;
            cnt = 0;
            while (hi < n)
            begin
                lo = hi;
                while (lo + 1 < n && level_at(lo + 1) != 0)
                    lo++;
                hi = lo + 1;
                while (hi < n && level_at(hi) == 0)
                    hi++;
                if (hi - lo > 1)
                begin
                    if (level_at(hi) <= 0)
                        stp = (level_at(lo) - level_at(lo - 1)) / 2;
                    else
                        stp = (level_at(hi) - level_at(lo)) / (hi - lo);
                    for (longint m = lo + 1; m < hi; m++)
                    begin
                        value_tbl[m]  = clamp32(level_at(m - 1) + stp);
                        weight_tbl[m] = fill_weight;
                        mark_tbl[m]   = 1;
                        if (cnt < int'(rgf_pkg::COUNT_MAX))
                            cnt++;
                    end
                end
            end
            return cnt[12:0];
        endfunction

        function void note_beat(rgf_pkg::in_item_t it);
            rgf_pkg::result_t r;
            r = '0;
            if (it.mode == rgf_pkg::MODE_LOAD)
            begin
                if (closed)
                begin
                    level_cnt = 0;
                    closed    = 0;
                end
                if (level_cnt < LEVELS)
                begin
                    value_tbl[level_cnt]  = it.response_value;
                    weight_tbl[level_cnt] = it.level_weight;
                    mark_tbl[level_cnt]   = 0;
                    if (!loaded[level_cnt])
                    begin
                        loaded[level_cnt] = 1;
                        loaded_idx.push_back(level_cnt);
                    end
                    level_cnt++;
                end
                if (!it.last)
                    return;
                fill_cnt      = fill_table();
                closed        = 1;
                r.result_kind = rgf_pkg::KIND_SUMMARY;
                r.gap_count   = fill_cnt;
            end
            else
            begin
                r.result_kind = rgf_pkg::KIND_READ;
                r.out_value   = value_tbl[it.read_index];
                r.out_weight  = weight_tbl[it.read_index];
                r.was_filled  = mark_tbl[it.read_index];
                r.gap_count   = fill_cnt;
            end
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("MISMATCH %0t %s: got %0h, want %0h", $realtime, what, got, want);
        endtask

        task check_beat(rgf_pkg::result_t r);
            rgf_pkg::result_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", 64'(r), 64'd0);
                return;
            end
            w = pending.pop_front();
            if (r.result_kind !== w.result_kind)
                report("result_kind", 64'(r.result_kind), 64'(w.result_kind));
            if (r.out_value !== w.out_value)
                report("out_value", 64'(r.out_value), 64'(w.out_value));
            if (r.out_weight !== w.out_weight)
                report("out_weight", 64'(r.out_weight), 64'(w.out_weight));
            if (r.was_filled !== w.was_filled)
                report("was_filled", 64'(r.was_filled), 64'(w.was_filled));
            if (r.gap_count !== w.gap_count)
                report("gap_count", 64'(r.gap_count), 64'(w.gap_count));
        endtask
    endclass

    curve_scoreboard sb;
    bit              steady;
    int              quiet_cycles;

    response_curve_gap_filler_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_beat(result);
    end

    // Watchdog on cycles with no beat in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // One beat: random idle cycles, then hold start until accepted
    task send(rgf_pkg::in_item_t it);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < 28)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        sb.note_beat(it);
    endtask

    task load_level(logic signed [31:0] v, logic [15:0] w, bit lst);
        rgf_pkg::in_item_t it;
        it                = '0;
        it.mode           = rgf_pkg::MODE_LOAD;
        it.response_value = v;
        it.level_weight   = w;
        it.last           = lst;
        it.read_index     = 12'($urandom);
        send(it);
    endtask

    task read_level(int idx);
        rgf_pkg::in_item_t it;
        it                = '0;
        it.mode           = rgf_pkg::MODE_READ;
        it.response_value = $urandom;
        it.level_weight   = 16'($urandom);
        it.last           = 1'($urandom);
        it.read_index     = 12'(idx);
        send(it);
    endtask

    task read_any();
        if (sb.loaded_idx.size() > 0)
            read_level(sb.loaded_idx[$urandom_range(sb.loaded_idx.size() - 1)]);
    endtask

    // Drain outstanding beats, let the block settle, then write the fill weight
    task set_fill_weight(logic [15:0] w);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.fill_weight = w;
    endtask

    function logic signed [31:0] rand_level();
        case ($urandom_range(9))
            0, 1, 2, 3: return 0;
            4, 5:       return $signed($urandom_range(2000)) - 1000;
            6:          return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default:    return $urandom;
        endcase
    endfunction

    // One curve load with random content, reads mixed in, reads after
    task run_curve(int len, int n_reads);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(5) == 0)
                read_any();
            load_level(rand_level(), 16'($urandom), i == len - 1);
        end
        repeat (n_reads) read_any();
    endtask

    initial
    begin
        int sent;
        sb        = new();
        steady    = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: gap at start, positive and non-positive ends, saturation, gap at end
        load_level(0, 16'h0000, 0);
        load_level(0, 16'hffff, 0);
        load_level(100, 16'h1234, 0);
        read_level(2);
        load_level(0, 16'h0001, 0);
        load_level(0, 16'h8000, 0);
        load_level(400, 16'h4000, 0);
        load_level(-5, 16'hffff, 0);
        load_level(0, 16'h0000, 0);
        load_level(0, 16'h0000, 0);
        load_level(50, 16'h7fff, 0);
        load_level(0, 16'h0000, 0);
        load_level(-20, 16'h00ff, 0);
        load_level(32'sh7fffff00, 16'hff00, 0);
        load_level(0, 16'h0000, 0);
        load_level(0, 16'h0000, 0);
        load_level(32'sh80000000, 16'haaaa, 0);
        load_level(0, 16'h5555, 0);
        load_level(0, 16'h0000, 1);
        for (int i = 0; i < 19; i++)
            read_level(i);

        // One-level table
        set_fill_weight(16'h0000);
        load_level(0, 16'hffff, 1);
        read_level(0);
        read_level(1);

        // Random curves under several weights
        sent = 0;
        while (sent < 1400)
        begin
            int len;
            set_fill_weight(16'($urandom));
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 30);
            steady = (sent >= 500 && sent < 700);
            run_curve(len, $urandom_range(2, 10));
            sent += len + 6;
        end

        // Drain
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
